[hw/rtl/imlc_pkg.sv]
// Shared types and constants for the ID mapping lookup cache.
// Used by imlc_slot_mem and id_mapping_lookup_cache; depends on nothing.
package imlc_pkg;

	localparam int SLOTS  = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int ID_W   = 64;
	localparam int TID_W  = 16;
	localparam int GEN_W  = 32;

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
	localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(SLOTS);

	// One cached mapping: 128-bit key and 128-bit bonded value.
	typedef struct packed {
		logic [ID_W-1:0] key_hi;
		logic [ID_W-1:0] key_lo;
		logic [ID_W-1:0] val_hi;
		logic [ID_W-1:0] val_lo;
	} entry_t;

endpackage

[hw/rtl/id_mapping_lookup_cache.sv]
// Top level of the ID mapping lookup cache: sequencer, owner tracking,
// valid bits, fill/evict pointers and result register. Depends on imlc_pkg
// and imlc_slot_mem.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid / in_stall       | func, table_present, table_id,
//          |                           | generation, key_hi/lo, answer_found,
//          |                           | answer_hi/lo
//  out     | out_valid / out_stall     | hit, need_answer, mapped_hi/lo
//
// Flow: a transaction with no table goes from accept to the push state and
// then the result register. With a table, the slot scan reads one slot per cycle from
// the slot memory through a single 128-bit key comparator.
// Reset: arst_n clears the sequencer, owner, pointers and all valid bits at
// once; slot contents are never read through an invalid slot, so no clearing
// pass is needed.
// Stalls: out_stall holds the result register; the block accepts the next
// transaction while a result waits, and holds a finished result in the push
// state until the result register frees up.
module id_mapping_lookup_cache (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic                       table_present,
	input  logic [imlc_pkg::TID_W-1:0] table_id,
	input  logic [imlc_pkg::GEN_W-1:0] generation,
	input  logic [imlc_pkg::ID_W-1:0]  key_hi,
	input  logic [imlc_pkg::ID_W-1:0]  key_lo,
	input  logic                       answer_found,
	input  logic [imlc_pkg::ID_W-1:0]  answer_hi,
	input  logic [imlc_pkg::ID_W-1:0]  answer_lo,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       need_answer,
	output logic [imlc_pkg::ID_W-1:0]  mapped_hi,
	output logic [imlc_pkg::ID_W-1:0]  mapped_lo
);
	import imlc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t state_q;

	// Captured transaction
	logic              func_q;
	logic              found_q;
	logic [ID_W-1:0]   key_hi_q;
	logic [ID_W-1:0]   key_lo_q;
	logic [ID_W-1:0]   ans_hi_q;
	logic [ID_W-1:0]   ans_lo_q;

	// Cache owner and replacement state
	logic              owner_known_q;
	logic [TID_W-1:0]  owner_table_q;
	logic [GEN_W-1:0]  owner_gen_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] evict_q;
	logic [SLOTS-1:0]  slot_valid_q;

	// Scan: read issue index and the compare stage that follows it
	logic [SLOT_W-1:0] scan_idx_q;
	logic              cmp_pend_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;

	// Finished result waiting for the output register
	logic              res_hit_q;
	logic              res_need_q;
	logic [ID_W-1:0]   res_hi_q;
	logic [ID_W-1:0]   res_lo_q;

	// Output register
	logic              out_valid_q;
	logic              out_hit_q;
	logic              out_need_q;
	logic [ID_W-1:0]   out_hi_q;
	logic [ID_W-1:0]   out_lo_q;

	entry_t            rd_entry;
	entry_t            wr_entry;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;

	logic in_accept;
	logic owner_change;
	logic key_match;
	logic slot_hit;
	logic scan_last;
	logic insert;
	logic fill_free;
	logic out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign owner_change = !owner_known_q || (owner_table_q != table_id) ||
		(owner_gen_q != generation);

	// Shared comparator: one slot per cycle
	assign key_match = (rd_entry.key_hi == key_hi_q) && (rd_entry.key_lo == key_lo_q);
	assign slot_hit  = cmp_pend_s1 && slot_valid_q[cmp_idx_s1] && key_match;
	assign scan_last = cmp_pend_s1 && (cmp_idx_s1 == LAST_SLOT);

	// Insert on a full miss of a func transaction that carries a found answer
	assign insert    = (state_q == ST_SCAN) && scan_last && !slot_hit && func_q && found_q;
	assign fill_free = (fill_q < FILL_FULL);
	assign wr_slot   = fill_free ? fill_q[SLOT_W-1:0] : evict_q;
	assign wr_en     = insert;

	always_comb begin
		wr_entry.key_hi = key_hi_q;
		wr_entry.key_lo = key_lo_q;
		wr_entry.val_hi = ans_hi_q;
		wr_entry.val_lo = ans_lo_q;
	end

	imlc_slot_mem u_slot_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_slot),
		.wr_data (wr_entry),
		.rd_addr (scan_idx_q),
		.rd_data (rd_entry)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, owner tracking and replacement pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			owner_known_q <= 1'b0;
			owner_table_q <= '0;
			owner_gen_q   <= '0;
			fill_q        <= '0;
			evict_q       <= '0;
			slot_valid_q  <= '0;
			scan_idx_q    <= '0;
			cmp_pend_s1   <= 1'b0;
			cmp_idx_s1    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						scan_idx_q  <= '0;
						cmp_pend_s1 <= 1'b0;
						if (!table_present) begin
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_SCAN;
							if (owner_change) begin
								// New owner: drop every slot and restart the fill
								owner_known_q <= 1'b1;
								owner_table_q <= table_id;
								owner_gen_q   <= generation;
								fill_q        <= '0;
								evict_q       <= '0;
								slot_valid_q  <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (slot_hit || scan_last) begin
						state_q     <= ST_PUSH;
						cmp_pend_s1 <= 1'b0;
						if (insert) begin
							slot_valid_q[wr_slot] <= 1'b1;
							if (fill_free) begin
								fill_q <= fill_q + 1'b1;
							end else begin
								evict_q <= (evict_q == LAST_SLOT) ? '0 : evict_q + 1'b1;
							end
						end
					end else begin
						// Advance: issue next read, compare the previous one
						cmp_pend_s1 <= 1'b1;
						cmp_idx_s1  <= scan_idx_q;
						scan_idx_q  <= scan_idx_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured transaction and pending result
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q     <= func;
			found_q    <= answer_found;
			key_hi_q   <= key_hi;
			key_lo_q   <= key_lo;
			ans_hi_q   <= answer_hi;
			ans_lo_q   <= answer_lo;
			// Passthrough result; overwritten by the scan when a table exists
			res_hit_q  <= 1'b0;
			res_need_q <= 1'b0;
			res_hi_q   <= key_hi;
			res_lo_q   <= key_lo;
		end else if (state_q == ST_SCAN) begin
			if (slot_hit) begin
				res_hit_q  <= 1'b1;
				res_need_q <= 1'b0;
				res_hi_q   <= rd_entry.val_hi;
				res_lo_q   <= rd_entry.val_lo;
			end else if (scan_last) begin
				res_hit_q  <= 1'b0;
				res_need_q <= !func_q;
				res_hi_q   <= insert ? ans_hi_q : key_hi_q;
				res_lo_q   <= insert ? ans_lo_q : key_lo_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_hit_q  <= res_hit_q;
			out_need_q <= res_need_q;
			out_hi_q   <= res_hi_q;
			out_lo_q   <= res_lo_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign need_answer = out_need_q;
	assign mapped_hi   = out_hi_q;
	assign mapped_lo   = out_lo_q;

	// A result never claims both a hit and a missing answer
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && need_answer))
		else $error("hit and need_answer both set");

	// Fill pointer never runs past the slot count
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill pointer out of range");

	// Eviction only moves once every slot has been filled
	a_evict_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(evict_q != '0) |-> (fill_q == FILL_FULL))
		else $error("evict pointer moved before fill completed");

	// A slot write always leaves that slot valid
	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> slot_valid_q[$past(wr_slot)])
		else $error("inserted slot not valid");

endmodule

[hw/rtl/imlc_slot_mem.sv]
// Slot storage for the ID mapping lookup cache: one write port, one
// registered read port. Depends on imlc_pkg.
module imlc_slot_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [imlc_pkg::SLOT_W-1:0] wr_addr,
	input  imlc_pkg::entry_t            wr_data,
	input  logic [imlc_pkg::SLOT_W-1:0] rd_addr,
	output imlc_pkg::entry_t            rd_data
);
	import imlc_pkg::*;

	entry_t mem [SLOTS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
